[sv/slps_pkg.sv]
// Shared types, codes and flash shape tables for the status LED sequencer.
// Used by the next-state logic and the top level; depends on nothing else.
`default_nettype none

package slps_pkg;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_MODE = 2'd1,
    OP_FLASH    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_DETACHED      = 2'd0,
    MODE_NETWORK_UP    = 2'd1,
    MODE_COMMISSIONING = 2'd2,
    MODE_NONE          = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FLASH_JOIN   = 2'd0,
    FLASH_FAILED = 2'd1,
    FLASH_RECV   = 2'd2,
    FLASH_ACK    = 2'd3
  } flash_e;

  typedef enum logic [1:0] {
    REG_SLOW_HALF   = 2'd0,
    REG_FAST_HALF   = 2'd1,
    REG_SHORT_PULSE = 2'd2,
    REG_LONG_PULSE  = 2'd3
  } reg_e;

  localparam logic [2:0] LED_OFF = 3'b000;
  localparam logic [2:0] LED_R   = 3'b001;
  localparam logic [2:0] LED_G   = 3'b010;
  localparam logic [2:0] LED_B   = 3'b100;

  localparam logic [5:0] SLOW_HALF_RST   = 6'd10;
  localparam logic [5:0] FAST_HALF_RST   = 6'd5;
  localparam logic [5:0] SHORT_PULSE_RST = 6'd2;
  localparam logic [5:0] LONG_PULSE_RST  = 6'd3;

  typedef struct packed {
    logic [5:0] slow_half;
    logic [5:0] fast_half;
    logic [5:0] short_pulse;
    logic [5:0] long_pulse;
  } slps_cfg_t;

  typedef struct packed {
    logic [1:0] hub_mode;
    logic       pending_valid;
    logic [1:0] pending_kind;
    logic       flash_active;
    logic [1:0] flash_kind;
    logic [2:0] phase_index;
    logic [5:0] phase_ticks;
    logic [6:0] slow_phase;
    logic [6:0] fast_phase;
    logic [2:0] led;
  } slps_state_t;

  function automatic logic [2:0] flash_phases(input logic [1:0] kind);
    logic [2:0] n;
    case (kind)
      FLASH_JOIN:   n = 3'd4;
      FLASH_FAILED: n = 3'd6;
      FLASH_RECV:   n = 3'd1;
      default:      n = 3'd2;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] flash_level(input logic [1:0] kind, input logic [2:0] idx);
    logic [2:0] lv;
    lv = LED_OFF;
    case (kind)
      FLASH_JOIN:   if (idx == 3'd0 || idx == 3'd2) lv = LED_G;
      FLASH_FAILED: if (idx == 3'd0 || idx == 3'd2 || idx == 3'd4) lv = LED_R;
      FLASH_RECV:   if (idx == 3'd0) lv = LED_B;
      default: begin
        if (idx == 3'd0) lv = LED_B;
        else if (idx == 3'd1) lv = LED_G;
      end
    endcase
    return lv;
  endfunction

  function automatic logic [6:0] next_phase(input logic [6:0] p, input logic [5:0] half);
    logic [7:0] n;
    n = {1'b0, p} + 8'd1;
    if (n >= {1'b0, half, 1'b0}) n = 8'd0;
    return n[6:0];
  endfunction

endpackage

`default_nettype wire

[sv/slps_next.sv]
// Next-state logic of the status LED sequencer for one accepted item.
// Depends on slps_pkg for the state, configuration and flash tables.
`default_nettype none

module slps_next (
  input  slps_pkg::slps_state_t st_i,
  input  slps_pkg::slps_cfg_t   cfg_i,
  input  logic [1:0]            op_i,
  input  logic [1:0]            arg_i,
  output slps_pkg::slps_state_t nx_o
);
  import slps_pkg::*;

  logic [5:0] pt;
  logic [5:0] len;
  logic [2:0] pi;
  logic       done;

  always_comb begin
    nx_o = st_i;
    pt   = st_i.phase_ticks + 6'd1;
    len  = st_i.flash_kind[1] ? cfg_i.long_pulse : cfg_i.short_pulse;
    pi   = st_i.phase_index + 3'd1;
    done = 1'b0;
    unique case (op_i)
      OP_TICK: begin
        if (st_i.flash_active) begin
          nx_o.phase_ticks = pt;
          if (pt >= len) begin
            nx_o.phase_ticks = 6'd0;
            if (pi >= flash_phases(st_i.flash_kind)) begin
              nx_o.flash_active = 1'b0;
              nx_o.phase_index  = 3'd0;
            end else begin
              nx_o.phase_index = pi;
              nx_o.led         = flash_level(st_i.flash_kind, pi);
            end
          end
          done = nx_o.flash_active;
        end
        if (!done) begin
          if (st_i.pending_valid) begin
            nx_o.pending_valid = 1'b0;
            nx_o.flash_kind    = st_i.pending_kind;
            nx_o.flash_active  = 1'b1;
            nx_o.phase_index   = 3'd0;
            nx_o.phase_ticks   = 6'd0;
            nx_o.slow_phase    = 7'd0;
            nx_o.fast_phase    = 7'd0;
            nx_o.led           = flash_level(st_i.pending_kind, 3'd0);
          end else begin
            case (st_i.hub_mode)
              MODE_DETACHED:
                nx_o.led = (st_i.slow_phase < {1'b0, cfg_i.slow_half}) ? LED_R : LED_OFF;
              MODE_NETWORK_UP:
                nx_o.led = LED_G;
              MODE_COMMISSIONING:
                nx_o.led = LED_G |
                           ((st_i.fast_phase < {1'b0, cfg_i.fast_half}) ? LED_B : LED_OFF);
              default: ;
            endcase
            nx_o.slow_phase = next_phase(st_i.slow_phase, cfg_i.slow_half);
            nx_o.fast_phase = next_phase(st_i.fast_phase, cfg_i.fast_half);
          end
        end
      end
      OP_SET_MODE: nx_o.hub_mode = arg_i;
      OP_FLASH: begin
        nx_o.pending_valid = 1'b1;
        nx_o.pending_kind  = arg_i;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[sv/status_led_pattern_sequencer.sv]
// Top level of the three-color status LED sequencer: state, configuration and result registers.
// Depends on slps_pkg and slps_next.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | op_i, arg_i
//   out     | output    | out_valid_o/out_ready_i | red/green/blue_led_o, flash_busy_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// The next state of each item is computed in one pass and stored with the result.
// One item is accepted per cycle while the result register is empty or being emptied.
// A stalled result holds the input back; nothing is lost or repeated.
// Reset clears the state to all LEDs off, detached mode, and loads the default periods.
`default_nettype none

module status_led_pattern_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [1:0] arg_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       red_led_o,
  output logic       green_led_o,
  output logic       blue_led_o,
  output logic       flash_busy_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [5:0] cfg_data_i
);
  import slps_pkg::*;

  slps_state_t state_q, state_d;
  slps_cfg_t   cfg_q;
  logic        out_valid_q;
  logic [3:0]  result_q;
  logic        in_xfer;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  slps_next u_next (
    .st_i  (state_q),
    .cfg_i (cfg_q),
    .op_i  (op_i),
    .arg_i (arg_i),
    .nx_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      result_q <= {state_d.flash_active, state_d.led};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow_half   <= SLOW_HALF_RST;
      cfg_q.fast_half   <= FAST_HALF_RST;
      cfg_q.short_pulse <= SHORT_PULSE_RST;
      cfg_q.long_pulse  <= LONG_PULSE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SLOW_HALF:   cfg_q.slow_half   <= cfg_data_i;
        REG_FAST_HALF:   cfg_q.fast_half   <= cfg_data_i;
        REG_SHORT_PULSE: cfg_q.short_pulse <= cfg_data_i;
        REG_LONG_PULSE:  cfg_q.long_pulse  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_led_o    = result_q[0];
  assign green_led_o  = result_q[1];
  assign blue_led_o   = result_q[2];
  assign flash_busy_o = result_q[3];

endmodule

`default_nettype wire

[sv/slps_checker.sv]
// Port-level checker for the status LED sequencer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module slps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       red_led_o,
  input logic       green_led_o,
  input logic       blue_led_o,
  input logic       flash_busy_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({red_led_o, green_led_o, blue_led_o, flash_busy_o}))
    else $error("Stalled result changed or was dropped.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("Result appeared without an input transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flash_busy_o |->
      $countones({red_led_o, green_led_o, blue_led_o}) <= 1)
    else $error("More than one LED lit during a flash.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && red_led_o |-> !green_led_o && !blue_led_o)
    else $error("Red LED lit together with another color.");

endmodule

bind status_led_pattern_sequencer slps_checker u_slps_checker (.*);

`default_nettype wire
